// ===== rtl/xor_delta_lzc_packer_assert.svh =====
// Assertion helpers for the packer checker.
`ifndef XOR_DELTA_LZC_PACKER_ASSERT_SVH
`define XOR_DELTA_LZC_PACKER_ASSERT_SVH

// Clocked check, quiet while reset is held.
`define XDLP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("xdlp check failed");

// Clocked check that also holds while reset is held.
`define XDLP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("xdlp check failed");

`endif

// ===== rtl/xdlp_pkg.sv =====
package xdlp_pkg;

    localparam int CFG_W           = 13;
    localparam int WORD_W          = 32;
    localparam int PREFIX_W        = 2;
    localparam int DEF_FRAME_DEPTH = 4096;

    localparam logic [CFG_W-1:0] FRAME_LEN_RESET = 13'd4096;
    localparam logic [1:0]       MAX_ZERO_BYTES  = 2'd3;

    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_COMPRESS   = 1'b1;
    localparam logic KIND_PREFIX   = 1'b0;
    localparam logic KIND_RESIDUAL = 1'b1;

    // item handed from the memory stage to the packer
    typedef struct packed {
        logic              opcode;
        logic [WORD_W-1:0] sample;
        logic [WORD_W-1:0] ref_word;
        logic              block_last;
    } item_t;

    typedef struct packed {
        logic              kind;
        logic [WORD_W-1:0] data;
        logic              blk_end;
    } out_word_t;

    // leading zero bytes, capped
    function automatic logic [1:0] zero_bytes(input logic [WORD_W-1:0] x);
        logic [1:0] zb;
        if (x[31:8] == 24'd0)
            zb = MAX_ZERO_BYTES;
        else if (x[31:16] == 16'd0)
            zb = 2'd2;
        else if (x[31:24] == 8'd0)
            zb = 2'd1;
        else
            zb = 2'd0;
        return zb;
    endfunction

endpackage

// ===== rtl/xdlp_packer.sv =====
module xdlp_packer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    input  xdlp_pkg::item_t           item,
    output logic                      item_done,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      stream_kind,
    output logic [xdlp_pkg::WORD_W-1:0] packed_word,
    output logic                      block_end,
    output logic                      last_of_run
);
    import xdlp_pkg::*;

    // packing state
    logic [WORD_W-1:0] pbuf_reg, pbuf_next;
    logic [4:0]        pfill_reg, pfill_next;
    logic [WORD_W-1:0] rbuf_reg, rbuf_next;
    logic [4:0]        rfill_reg, rfill_next;

    // word sequencer and output register
    logic [1:0]        sub_reg, sub_next;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_reg;

    logic [WORD_W-1:0] delta, value, mask, p_or, r_or;
    logic [1:0]        zb, n_words;
    logic [5:0]        nbits, space, p_sum, r_sum, rest;
    logic              fits, emitted, is_cmp, move, last_word;
    out_word_t         lst [3];
    out_word_t         sel;

    always_comb
    begin
        is_cmp = item_valid && (item.opcode == OP_COMPRESS);
        delta  = item.sample ^ item.ref_word;
        zb     = zero_bytes(delta);

        lst[0]  = '0;
        lst[1]  = '0;
        lst[2]  = '0;
        n_words = 2'd0;

        // prefix stream: two bits, never straddles
        p_or      = pbuf_reg | (WORD_W'(zb) << (5'd30 - pfill_reg));
        p_sum     = 6'(pfill_reg) + 6'(PREFIX_W);
        pbuf_next = p_or;
        pfill_next = p_sum[4:0];
        if (p_sum == 6'd32 || item.block_last)
        begin
            lst[0]     = '{kind: KIND_PREFIX, data: p_or, blk_end: item.block_last};
            n_words    = 2'd1;
            pbuf_next  = '0;
            pfill_next = '0;
        end

        // residual stream: 8..32 bits, may straddle
        nbits   = 6'd32 - {1'b0, zb, 3'b000};
        mask    = (WORD_W'(1) << nbits) - WORD_W'(1);
        value   = delta & mask;
        space   = 6'd32 - 6'(rfill_reg);
        fits    = (nbits <= space);
        r_or    = rbuf_reg | (value << (space - nbits));
        r_sum   = 6'(rfill_reg) + nbits;
        rest    = nbits - space;
        emitted = 1'b0;
        if (fits)
        begin
            rbuf_next  = r_or;
            rfill_next = r_sum[4:0];
            if (r_sum == 6'd32)
            begin
                lst[n_words] = '{kind: KIND_RESIDUAL, data: r_or,
                                 blk_end: item.block_last};
                n_words      = n_words + 2'd1;
                rbuf_next    = '0;
                rfill_next   = '0;
                emitted      = 1'b1;
            end
        end
        else
        begin
            lst[n_words] = '{kind: KIND_RESIDUAL, data: rbuf_reg | (value >> rest),
                             blk_end: 1'b0};
            n_words      = n_words + 2'd1;
            rbuf_next    = value << (6'd32 - rest);
            rfill_next   = rest[4:0];
        end
        if (item.block_last && !emitted)
        begin
            lst[n_words] = '{kind: KIND_RESIDUAL, data: rbuf_next, blk_end: 1'b1};
            n_words      = n_words + 2'd1;
            rbuf_next    = '0;
            rfill_next   = '0;
        end
        if (!is_cmp)
            n_words = 2'd0;

        case (sub_reg)
            2'd0:    sel = lst[0];
            2'd1:    sel = lst[1];
            2'd2:    sel = lst[2];
            default: sel = lst[0];
        endcase

        // a compress that fills no word only updates the buffers
        move      = is_cmp && (n_words != 2'd0) && (!out_valid_reg || out_ready);
        last_word = (sub_reg == n_words - 2'd1);
        item_done = item_valid && (!is_cmp || (n_words == 2'd0) || (move && last_word));

        sub_next = sub_reg;
        if (move)
            sub_next = last_word ? 2'd0 : sub_reg + 2'd1;

        out_valid_next = out_valid_reg;
        if (move)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pbuf_reg      <= '0;
            pfill_reg     <= '0;
            rbuf_reg      <= '0;
            rfill_reg     <= '0;
            sub_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sub_reg       <= sub_next;
            out_valid_reg <= out_valid_next;
            if (is_cmp && item_done)
            begin
                pbuf_reg  <= pbuf_next;
                pfill_reg <= pfill_next;
                rbuf_reg  <= rbuf_next;
                rfill_reg <= rfill_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_reg     <= sel;
            last_of_run <= last_word;
        end
    end

    assign out_valid   = out_valid_reg;
    assign stream_kind = out_reg.kind;
    assign packed_word = out_reg.data;
    assign block_end   = out_reg.blk_end;

endmodule

// ===== rtl/xor_delta_lzc_packer.sv =====
// XOR-delta float packer. Each input word is a 32-bit float bit pattern in
// frame order. A load (opcode 0) writes the reference frame at the current
// frame position; a compress (opcode 1) XORs the sample with the reference
// word there, stores the sample back, and packs a 2-bit leading-zero-byte
// count (capped at 3) into the prefix stream and the low 32-8*count XOR bits
// into the residual stream, both MSB-first. Full words leave as they fill;
// block_last on a compress flushes both streams zero-padded, and each
// stream's final word of the block carries block_end. last_of_run marks the
// last result word of an input word; prefix words precede residual words.
// Rate while out_ready is high: one input word per cycle if each item yields
// at most one result; an item with k results (k up to 3) holds intake until
// its last leaves, as results leave one per cycle via one output register.
// Loads yield no results. The reference frame is one single-port RAM,
// read-first: each accepted word reads the old reference and writes the new
// sample at the same address in the same cycle, so back-to-back hits on one
// entry need no forwarding. The frame RAM holds no reset contents; a
// compress against an entry never written since reset returns an arbitrary
// delta. Users write frame_length (reset 4096) only while idle; the block
// does not enforce this. 0 acts as 1 and values above FRAME_DEPTH clamp.
module xor_delta_lzc_packer #(
    parameter int FRAME_DEPTH = xdlp_pkg::DEF_FRAME_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [xdlp_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [xdlp_pkg::WORD_W-1:0]  sample,
    input  logic                         block_last,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         stream_kind,
    output logic [xdlp_pkg::WORD_W-1:0]  packed_word,
    output logic                         block_end,
    output logic                         last_of_run
);
    import xdlp_pkg::*;

    localparam int POS_W = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int DEP_W = $clog2(FRAME_DEPTH + 1);
    localparam int LEN_W = (DEP_W > CFG_W) ? DEP_W : CFG_W;

    logic [CFG_W-1:0]  frame_len_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_ext, eff_len, pos_inc;

    // frame reference RAM, one port, read-first
    logic [WORD_W-1:0] ref_mem [FRAME_DEPTH];
    logic [WORD_W-1:0] rd_reg;

    // stage one: item waiting on reference data / packer
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_op_reg, s1_last_reg;
    logic [WORD_W-1:0] s1_sample_reg;
    item_t             s1_item;
    logic              s1_done;
    logic              accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = !s1_valid_reg || s1_done;
    assign accept    = in_valid && in_ready;

    // frame position wrap against the clamped length
    always_comb
    begin
        len_ext = LEN_W'(frame_len_reg);
        if (len_ext == '0)
            eff_len = LEN_W'(1);
        else if (len_ext > LEN_W'(FRAME_DEPTH))
            eff_len = LEN_W'(FRAME_DEPTH);
        else
            eff_len = len_ext;
        pos_inc  = LEN_W'(pos_reg) + LEN_W'(1);
        pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[POS_W-1:0];

        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_len_reg <= FRAME_LEN_RESET;
            pos_reg       <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                frame_len_reg <= cfg_data;
            if (accept)
                pos_reg <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // old reference out, new sample in, same address
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg           <= ref_mem[pos_reg];
            ref_mem[pos_reg] <= sample;
            s1_op_reg        <= opcode;
            s1_sample_reg    <= sample;
            s1_last_reg      <= block_last;
        end
    end

    assign s1_item = '{opcode: s1_op_reg, sample: s1_sample_reg,
                       ref_word: rd_reg, block_last: s1_last_reg};

    xdlp_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s1_valid_reg),
        .item        (s1_item),
        .item_done   (s1_done),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .stream_kind (stream_kind),
        .packed_word (packed_word),
        .block_end   (block_end),
        .last_of_run (last_of_run)
    );

endmodule

// ===== rtl/xdlp_checker.sv =====
`include "xor_delta_lzc_packer_assert.svh"

module xdlp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic                        stream_kind,
    input logic [xdlp_pkg::WORD_W-1:0] packed_word,
    input logic                        block_end,
    input logic                        last_of_run
);
    import xdlp_pkg::*;

    // stalled result word holds
    `XDLP_ASSERT(a_out_hold, clk, rst_n,
        out_valid && !out_ready |=> out_valid && $stable(packed_word) && $stable(stream_kind))

    // residual flush closes the item
    `XDLP_ASSERT(a_res_end_last, clk, rst_n,
        out_valid && block_end && (stream_kind == KIND_RESIDUAL) |-> last_of_run)

    // a block end always has a residual word after its prefix word
    `XDLP_ASSERT(a_pre_end_not_last, clk, rst_n,
        out_valid && block_end && (stream_kind == KIND_PREFIX) |-> !last_of_run)

    // nothing offered during reset
    `XDLP_ASSERT_ALWAYS(a_rst_quiet, clk, !rst_n |-> !out_valid)

endmodule

bind xor_delta_lzc_packer xdlp_checker u_xdlp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .stream_kind (stream_kind),
    .packed_word (packed_word),
    .block_end   (block_end),
    .last_of_run (last_of_run)
);
